### rtl/dap_pkg.sv
`default_nettype none

package dap_pkg;

    localparam int CH_W = 8;
    localparam int CNT_W = 4;
    localparam int DIGIT_W = 4;
    localparam int SCALE_W = 27;
    localparam int PROD_W = DIGIT_W + SCALE_W;
    localparam int AMOUNT_W = 60;
    localparam int M_TDATA_W = ((AMOUNT_W + 7) / 8) * 8;

    localparam int DEFAULT_FRACTION_DIGITS = 8;
    localparam int DEFAULT_MAX_WHOLE_DIGITS = 10;

    localparam logic [CH_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CH_W-1:0] CHAR_DOT = 8'h2E;
    localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [CH_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [3:0] DIGIT_HI_NIBBLE = 4'h3;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef enum logic [5:0] {
        PH_LEAD  = 6'b000001,
        PH_WHOLE = 6'b000010,
        PH_FRAC  = 6'b000100,
        PH_TRAIL = 6'b001000,
        PH_FAIL  = 6'b010000,
        PH_ENDED = 6'b100000
    } phase_t;

    function automatic logic [SCALE_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [SCALE_W-1:0] r;
        unique case (n)
            4'd0: r = 27'd1;
            4'd1: r = 27'd10;
            4'd2: r = 27'd100;
            4'd3: r = 27'd1000;
            4'd4: r = 27'd10000;
            4'd5: r = 27'd100000;
            4'd6: r = 27'd1000000;
            4'd7: r = 27'd10000000;
            4'd8: r = 27'd100000000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/decimal_amount_parser.sv
// The result beat is presented in the cycle after the beat marked tlast is accepted.
// Throughput: one byte per cycle; s_tready drops only while a result waits on m_tready.
// A whole digit is a 60-bit multiply-by-ten and add; a fraction digit adds a scaled term.
// Reset: aresetn is synchronous and active low; it returns the parser to the
// leading whitespace phase with a zero amount and drops m_tvalid.
`default_nettype none

module decimal_amount_parser
    import dap_pkg::*;
#(
    parameter int FRACTION_DIGITS = DEFAULT_FRACTION_DIGITS,
    parameter int MAX_WHOLE_DIGITS = DEFAULT_MAX_WHOLE_DIGITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CH_W-1:0]      s_tdata,   // ch[7:0]
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // amount[59:0], zero fill above
    output logic [0:0]                m_tuser    // ok[0]
);

    localparam logic [SCALE_W-1:0] WHOLE_SCALE = pow10(CNT_W'(FRACTION_DIGITS));

    phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]       whole_cnt_reg, whole_cnt_next;
    logic [CNT_W-1:0]       frac_cnt_reg, frac_cnt_next;
    logic [AMOUNT_W-1:0]    acc_reg, acc_next;
    logic                   m_valid_reg;
    logic                   ok_reg;
    logic [AMOUNT_W-1:0]    amount_reg;

    logic                   beat_in;
    logic                   is_ws;
    logic                   is_digit;
    logic [DIGIT_W-1:0]     digit;
    logic [SCALE_W-1:0]     frac_scale;
    logic [PROD_W-1:0]      whole_term;
    logic [PROD_W-1:0]      frac_term;
    phase_t                 phase_eff;

    assign s_tready = !m_valid_reg || m_tready;
    assign beat_in  = s_tvalid && s_tready;

    assign is_ws    = (s_tdata == CHAR_SPACE) || (s_tdata >= CHAR_TAB && s_tdata <= CHAR_CR);
    assign is_digit = (s_tdata[7:4] == DIGIT_HI_NIBBLE) && (s_tdata[3:0] <= DIGIT_MAX);
    assign digit    = s_tdata[3:0];

    assign frac_scale = pow10(CNT_W'(FRACTION_DIGITS - 1) - frac_cnt_reg);
    assign whole_term = PROD_W'(digit) * PROD_W'(WHOLE_SCALE);
    assign frac_term  = PROD_W'(digit) * PROD_W'(frac_scale);

    always_comb begin
        phase_next     = phase_reg;
        whole_cnt_next = whole_cnt_reg;
        frac_cnt_next  = frac_cnt_reg;
        acc_next       = acc_reg;
        phase_eff      = phase_reg;
        if (phase_reg == PH_LEAD && !is_ws) begin
            phase_eff = PH_WHOLE;
        end
        if (phase_reg != PH_FAIL && phase_reg != PH_ENDED) begin
            if (s_tdata == CHAR_NUL) begin
                phase_next = PH_ENDED;
            end else begin
                unique case (phase_eff)
                    PH_LEAD: begin
                        phase_next = PH_LEAD;
                    end
                    PH_WHOLE: begin
                        phase_next = PH_WHOLE;
                        if (s_tdata == CHAR_DOT) begin
                            phase_next = PH_FRAC;
                        end else if (is_ws) begin
                            phase_next = PH_TRAIL;
                        end else if (is_digit && whole_cnt_reg < CNT_W'(MAX_WHOLE_DIGITS)) begin
                            acc_next = (acc_reg << 3) + (acc_reg << 1)
                                     + AMOUNT_W'(whole_term);
                            whole_cnt_next = whole_cnt_reg + CNT_W'(1);
                        end else begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit && frac_cnt_reg < CNT_W'(FRACTION_DIGITS)) begin
                            acc_next = acc_reg + AMOUNT_W'(frac_term);
                            frac_cnt_next = frac_cnt_reg + CNT_W'(1);
                        end else if (is_ws) begin
                            phase_next = PH_TRAIL;
                        end else begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_TRAIL: begin
                        if (!is_ws) begin
                            phase_next = PH_FAIL;
                        end
                    end
                    default: begin
                        phase_next = PH_FAIL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LEAD;
            whole_cnt_reg <= '0;
            frac_cnt_reg  <= '0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (beat_in && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (beat_in) begin
                if (s_tlast) begin
                    phase_reg     <= PH_LEAD;
                    whole_cnt_reg <= '0;
                    frac_cnt_reg  <= '0;
                    acc_reg       <= '0;
                end else begin
                    phase_reg     <= phase_next;
                    whole_cnt_reg <= whole_cnt_next;
                    frac_cnt_reg  <= frac_cnt_next;
                    acc_reg       <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_in && s_tlast) begin
            ok_reg     <= (phase_next != PH_FAIL);
            amount_reg <= (phase_next != PH_FAIL) ? acc_next : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(amount_reg);
    assign m_tuser  = ok_reg;

endmodule

`default_nettype wire

### rtl/dap_checker.sv
`default_nettype none

module dap_checker
    import dap_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tlast,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]           m_tuser
);

    // A beat marked last always produces a result beat in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last beat");

    // A taken result is not followed by another unless a last beat came in.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(s_tvalid && s_tready && s_tlast) |=> !m_tvalid)
        else $error("result without last beat");

    // A failed parse reports a zero amount.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero amount on failure");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind decimal_amount_parser dap_checker u_dap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### test/decimal_amount_parser_checker.sv
`default_nettype none

module decimal_amount_parser_checker
    import dap_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [CH_W-1:0]      s_tdata,   // ch[7:0]
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,   // amount[59:0], zero fill above
    input  wire logic [0:0]           m_tuser,   // ok[0]
    output int                        mismatches,
    output int                        outstanding,
    output int                        results_checked,
    output int                        valid_amounts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_DIGITS = DEFAULT_FRACTION_DIGITS;
    localparam int WHOLE_LIMIT = DEFAULT_MAX_WHOLE_DIGITS;
    localparam int RADIX = 10;

    typedef struct packed {
        logic                ok;
        logic [AMOUNT_W-1:0] amount;
    } parse_result_t;

    parse_result_t amounts_due[$];

    phase_t      scan_phase;
    logic [33:0] whole_acc;
    int          whole_digits;
    logic [26:0] frac_acc;
    int          frac_digits;

    initial begin
        mismatches = 0;
        outstanding = 0;
        results_checked = 0;
        valid_amounts = 0;
    end

    function automatic bit is_space(input logic [CH_W-1:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_digit(input logic [CH_W-1:0] c);
        return c[7:4] == DIGIT_HI_NIBBLE && c[3:0] <= DIGIT_MAX;
    endfunction

    task automatic clear_scan();
        scan_phase = PH_LEAD;
        whole_acc = '0;
        whole_digits = 0;
        frac_acc = '0;
        frac_digits = 0;
    endtask

    task automatic scan_byte(input logic [CH_W-1:0] c);
        if (scan_phase == PH_FAIL || scan_phase == PH_ENDED) begin
            return;
        end
        if (c == CHAR_NUL) begin
            scan_phase = PH_ENDED;
            return;
        end
        if (scan_phase == PH_LEAD) begin
            if (is_space(c)) begin
                return;
            end
            scan_phase = PH_WHOLE;
        end
        case (scan_phase)
            PH_WHOLE: begin
                if (c == CHAR_DOT) begin
                    scan_phase = PH_FRAC;
                end else if (is_space(c)) begin
                    scan_phase = PH_TRAIL;
                end else if (is_digit(c) && whole_digits < WHOLE_LIMIT) begin
                    whole_acc = 34'(whole_acc * RADIX + c[3:0]);
                    whole_digits++;
                end else begin
                    scan_phase = PH_FAIL;
                end
            end
            PH_FRAC: begin
                if (is_digit(c) && frac_digits < FRAC_DIGITS) begin
                    frac_acc = 27'(frac_acc * RADIX + c[3:0]);
                    frac_digits++;
                end else if (is_space(c)) begin
                    scan_phase = PH_TRAIL;
                end else begin
                    scan_phase = PH_FAIL;
                end
            end
            default: begin
                if (!is_space(c)) begin
                    scan_phase = PH_FAIL;
                end
            end
        endcase
    endtask

    function automatic parse_result_t settle_amount();
        parse_result_t r;
        logic [63:0]   coin;
        logic [63:0]   frac_scale;
        int            i;
        coin = 64'd1;
        frac_scale = 64'd1;
        for (i = 0; i < FRAC_DIGITS; i++) begin
            coin = coin * RADIX;
        end
        for (i = frac_digits; i < FRAC_DIGITS; i++) begin
            frac_scale = frac_scale * RADIX;
        end
        r = '0;
        if (scan_phase != PH_FAIL) begin
            r.ok = 1'b1;
            r.amount = AMOUNT_W'(64'(whole_acc) * coin + 64'(frac_acc) * frac_scale);
        end
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            clear_scan();
            amounts_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (amounts_due.size() == 0) begin
                    report($sformatf("result beat with nothing pending, ok=%0b amount=%0d",
                                     m_tuser[0], m_tdata[AMOUNT_W-1:0]));
                end else begin
                    want = amounts_due.pop_front();
                    results_checked++;
                    if (want.ok) begin
                        valid_amounts++;
                    end
                    if (m_tuser[0] !== want.ok) begin
                        report($sformatf("ok flag %b, expected %b", m_tuser[0], want.ok));
                    end
                    if (m_tdata[AMOUNT_W-1:0] !== want.amount) begin
                        report($sformatf("amount %0d, expected %0d",
                                         m_tdata[AMOUNT_W-1:0], want.amount));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata);
                if (s_tlast) begin
                    amounts_due.push_back(settle_amount());
                    clear_scan();
                end
            end
        end
        outstanding <= amounts_due.size();
    end

endmodule

`default_nettype wire

### test/decimal_amount_parser_tb.sv
`default_nettype none

module decimal_amount_parser_tb
    import dap_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1300;
    localparam int SETTLE_CYCLES = 10;
    localparam logic [CH_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [CH_W-1:0] CHAR_VT = 8'h0B;
    localparam logic [CH_W-1:0] CHAR_FF = 8'h0C;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CH_W-1:0]      s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    int mismatches;
    int outstanding;
    int results_checked;
    int valid_amounts;

    int send_idle_pct = 37;
    int recv_idle_pct = 78;
    int cycle_cnt = 0;
    int bytes_sent = 0;
    int strings_sent = 0;

    logic [CH_W-1:0] text[$];

    always #2 aclk = ~aclk;

    decimal_amount_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    decimal_amount_parser_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .valid_amounts  (valid_amounts)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [CH_W-1:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic send_chars(input string s);
        text.delete();
        foreach (s[i]) begin
            text.push_back(s[i]);
        end
        send_text();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [CH_W-1:0] pick_space();
        case ($urandom_range(5))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_LF;
            3: return CHAR_VT;
            4: return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_digit(input bit nines);
        return {DIGIT_HI_NIBBLE, nines ? DIGIT_MAX : 4'($urandom_range(9))};
    endfunction

    task automatic compose_amount(input int whole_n, input bit dot, input int frac_n);
        bit nines;
        nines = ($urandom_range(5) == 0);
        repeat ($urandom_range(3)) text.push_back(pick_space());
        repeat (whole_n) text.push_back(pick_digit(nines));
        if (dot) begin
            text.push_back(CHAR_DOT);
        end
        repeat (frac_n) text.push_back(pick_digit(nines));
        repeat ($urandom_range(2)) text.push_back(pick_space());
        if ($urandom_range(3) == 0) begin
            text.push_back(CHAR_NUL);
            repeat ($urandom_range(2)) text.push_back(CH_W'($urandom_range(255)));
        end
    endtask

    task automatic random_string();
        int pick;
        int whole_n;
        int frac_n;
        bit dot;
        text.delete();
        pick = $urandom_range(99);
        whole_n = ($urandom_range(2) == 0) ? DEFAULT_MAX_WHOLE_DIGITS
                                           : $urandom_range(DEFAULT_MAX_WHOLE_DIGITS);
        dot = 1'($urandom_range(1));
        frac_n = !dot ? 0 : ($urandom_range(2) == 0) ? DEFAULT_FRACTION_DIGITS
                                                     : $urandom_range(DEFAULT_FRACTION_DIGITS);
        if (pick < 70) begin
            compose_amount(whole_n, dot, frac_n);
        end else if (pick < 82) begin
            if ($urandom_range(1)) begin
                compose_amount(DEFAULT_MAX_WHOLE_DIGITS + 1, dot, frac_n);
            end else begin
                compose_amount(whole_n, 1'b1, DEFAULT_FRACTION_DIGITS + 1);
            end
        end else if (pick < 93) begin
            compose_amount(whole_n, dot, frac_n);
            text.insert($urandom_range(text.size()),
                        $urandom_range(1) ? pick_space() : CH_W'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(6, 1)) text.push_back(CH_W'($urandom_range(255)));
        end
        if (text.size() == 0) begin
            text.push_back(pick_space());
        end
        send_text();
    endtask

    initial begin
        int stage;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_chars("\t7");
        send_chars(".5 ");
        send_chars("1 2");
        send_chars("x");
        send_chars(".");
        send_chars("\r");
        send_chars("0.00000001");
        text = '{CHAR_NUL};
        send_text();
        text = '{"3", CHAR_NUL, 8'hFF};
        send_text();
        text = '{"8", CHAR_DOT, 8'h80};
        send_text();
        wait_drained();

        for (stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (bytes_sent < ITEM_TARGET * (stage + 1) / 3) begin
                random_string();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d strings in %0d bytes over three sender/receiver idle patterns.",
                 strings_sent, bytes_sent);
        $display("Checked %0d results, %0d of them valid amounts.",
                 results_checked, valid_amounts);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/dap_pkg.sv
rtl/decimal_amount_parser.sv
rtl/dap_checker.sv
test/decimal_amount_parser_checker.sv
test/decimal_amount_parser_tb.sv
